// File: sv/alle_pkg.sv
// Shared types and constants for the array linked list engine.
// No dependencies; every other file refers to this package by scoped names.
package alle_pkg;

    localparam int NODE_COUNT = 16;
    localparam int PTR_W      = $clog2(NODE_COUNT + 1);
    localparam int IDX_W      = $clog2(NODE_COUNT);

    // A null link is the value NODE_COUNT.
    localparam logic [PTR_W-1:0] LINK_NULL = PTR_W'(NODE_COUNT);

    // Input kind codes
    localparam logic [1:0] KIND_INS_HEAD = 2'd0;
    localparam logic [1:0] KIND_INS_TAIL = 2'd1;
    localparam logic [1:0] KIND_DEL_HEAD = 2'd2;
    localparam logic [1:0] KIND_READ_OUT = 2'd3;

    typedef enum logic [1:0] {
        OP_INS_HEAD,
        OP_INS_TAIL,
        OP_DEL_HEAD,
        OP_READ_OUT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_WALK,
        S_DEL,
        S_READ
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] item_value;
        logic               is_last;
    } t_res;

    function automatic logic is_node(input logic [PTR_W-1:0] p);
        return p < PTR_W'(NODE_COUNT);
    endfunction

endpackage

// File: sv/alle_front.sv
// Front end: accepts transactions, decodes the kind into an operation and
// holds them in a two-entry command queue. Depends on alle_pkg.
module alle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop,
    output alle_pkg::t_cmd     o_cmd
);

    alle_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    alle_pkg::t_op  op;
    logic           do_push;
    logic           do_pop;

    always_comb begin
        case (i_kind)
            alle_pkg::KIND_INS_HEAD: op = alle_pkg::OP_INS_HEAD;
            alle_pkg::KIND_INS_TAIL: op = alle_pkg::OP_INS_TAIL;
            alle_pkg::KIND_DEL_HEAD: op = alle_pkg::OP_DEL_HEAD;
            alle_pkg::KIND_READ_OUT: op = alle_pkg::OP_READ_OUT;
            default:                 op = alle_pkg::OP_READ_OUT;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= '{op: op, value: i_value};
        end
    end

endmodule

// File: sv/alle_res_queue.sv
// Result queue: two entries between the list sequencer and the output port.
// Depends on alle_pkg.
module alle_res_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  alle_pkg::t_res i_res,
    output logic           o_full,
    output logic           empty,
    input  logic           pop,
    output alle_pkg::t_res o_res
);

    alle_pkg::t_res r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign empty   = (r_count == 2'd0);
    assign o_res   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

// File: sv/alle_back.sv
// Back end: list sequencer with the node store (data and link memories),
// list and free heads. Depends on alle_pkg.
module alle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  alle_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output alle_pkg::t_res o_res
);

    localparam int PW = alle_pkg::PTR_W;
    localparam int IW = alle_pkg::IDX_W;
    localparam int NC = alle_pkg::NODE_COUNT;

    alle_pkg::t_state   r_state, n_state;
    alle_pkg::t_op      r_op, n_op;
    logic signed [31:0] r_value, n_value;
    logic [PW-1:0]      r_list_head, n_list_head;
    logic [PW-1:0]      r_free_head, n_free_head;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [PW-1:0]      r_new, n_new;
    logic [PW-1:0]      r_steps, n_steps;

    // Node store
    logic [PW-1:0]      r_link_mem [NC];
    logic [31:0]        r_data_mem [NC];
    logic [NC-1:0]      r_link_set;
    logic [PW-1:0]      r_rd_link;
    logic [31:0]        r_rd_data;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               link_we;
    logic [IW-1:0]      link_wa;
    logic [PW-1:0]      link_wd;
    logic               data_we;
    logic [IW-1:0]      data_wa;
    logic last_elem;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_value     = r_value;
        n_list_head = r_list_head;
        n_free_head = r_free_head;
        n_ptr       = r_ptr;
        n_new       = r_new;
        n_steps     = r_steps;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '{status: alle_pkg::ST_OK, item_value: '0, is_last: 1'b1};
        rd_en       = 1'b0;
        rd_addr     = '0;
        link_we     = 1'b0;
        link_wa     = '0;
        link_wd     = alle_pkg::LINK_NULL;
        data_we     = 1'b0;
        data_wa     = '0;
        last_elem   = !alle_pkg::is_node(r_rd_link) || (r_steps == PW'(NC - 1));

        case (r_state)
            alle_pkg::S_IDLE: begin
                // Take a command only when a result slot is free.
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_value   = i_cmd.value;
                    n_steps   = '0;
                    case (i_cmd.op)
                        alle_pkg::OP_INS_HEAD, alle_pkg::OP_INS_TAIL: begin
                            if (!alle_pkg::is_node(r_free_head)) begin
                                o_res_push   = 1'b1;
                                o_res.status = alle_pkg::ST_FULL;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_free_head[IW-1:0];
                                n_state = alle_pkg::S_TAKE;
                            end
                        end
                        alle_pkg::OP_DEL_HEAD, alle_pkg::OP_READ_OUT: begin
                            if (!alle_pkg::is_node(r_list_head)) begin
                                o_res_push   = 1'b1;
                                o_res.status = alle_pkg::ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_list_head[IW-1:0];
                                n_state = (i_cmd.op == alle_pkg::OP_DEL_HEAD) ?
                                          alle_pkg::S_DEL : alle_pkg::S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            alle_pkg::S_TAKE: begin
                // Pop the free node and fill it.
                n_free_head = r_rd_link;
                data_we     = 1'b1;
                data_wa     = r_free_head[IW-1:0];
                link_we     = 1'b1;
                link_wa     = r_free_head[IW-1:0];
                link_wd     = (r_op == alle_pkg::OP_INS_HEAD) ? r_list_head
                                                               : alle_pkg::LINK_NULL;
                if (r_op == alle_pkg::OP_INS_HEAD || !alle_pkg::is_node(r_list_head)) begin
                    n_list_head = r_free_head;
                    o_res_push  = 1'b1;
                    n_state     = alle_pkg::S_IDLE;
                end else begin
                    n_ptr   = r_list_head;
                    n_new   = r_free_head;
                    rd_en   = 1'b1;
                    rd_addr = r_list_head[IW-1:0];
                    n_state = alle_pkg::S_WALK;
                end
            end

            alle_pkg::S_WALK: begin
                if (!alle_pkg::is_node(r_rd_link) || r_steps == PW'(NC)) begin
                    link_we    = 1'b1;
                    link_wa    = r_ptr[IW-1:0];
                    link_wd    = r_new;
                    o_res_push = 1'b1;
                    n_state    = alle_pkg::S_IDLE;
                end else begin
                    n_ptr   = r_rd_link;
                    rd_en   = 1'b1;
                    rd_addr = r_rd_link[IW-1:0];
                    n_steps = r_steps + PW'(1);
                end
            end

            alle_pkg::S_DEL: begin
                // Return the old head to the front of the free list.
                n_list_head = r_rd_link;
                n_free_head = r_list_head;
                link_we     = 1'b1;
                link_wa     = r_list_head[IW-1:0];
                link_wd     = r_free_head;
                o_res_push  = 1'b1;
                n_state     = alle_pkg::S_IDLE;
            end

            alle_pkg::S_READ: begin
                // Hold the fetched node until the result queue has room.
                if (!i_res_full) begin
                    o_res_push       = 1'b1;
                    o_res.item_value = r_rd_data;
                    o_res.is_last    = last_elem;
                    if (last_elem) begin
                        n_state = alle_pkg::S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_rd_link[IW-1:0];
                        n_steps = r_steps + PW'(1);
                    end
                end
            end

            default: n_state = alle_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alle_pkg::S_IDLE;
            r_list_head <= alle_pkg::LINK_NULL;
            r_free_head <= '0;
            r_steps     <= '0;
            r_link_set  <= '0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_steps     <= n_steps;
            if (link_we) r_link_set[link_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_value <= n_value;
        r_ptr   <= n_ptr;
        r_new   <= n_new;
    end

    // Node store: one write per memory, one registered read per cycle.
    // A link never written reads as its reset chain value (index plus one).
    always_ff @(posedge i_clk) begin
        if (link_we) r_link_mem[link_wa] <= link_wd;
        if (data_we) r_data_mem[data_wa] <= r_value;
        if (rd_en) begin
            r_rd_link <= r_link_set[rd_addr] ? r_link_mem[rd_addr]
                                             : PW'(rd_addr) + PW'(1);
            r_rd_data <= r_data_mem[rd_addr];
        end
    end

    a_heads_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alle_pkg::is_node(r_list_head) |-> (r_list_head != r_free_head))
        else $error("list head and free head point to the same node");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full result queue");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == alle_pkg::S_IDLE))
        else $error("command taken while an operation is in progress");

    a_readout_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alle_pkg::S_READ && o_res_push && !o_res.is_last)
        |=> (r_state == alle_pkg::S_READ))
        else $error("read-out stopped before its last element");

endmodule

// File: sv/array_linked_list_engine.sv
// Array linked list engine top level: command front end, list sequencer and
// result queue. Depends on alle_pkg, alle_front, alle_back, alle_res_queue.
//
// Each transaction is one operation on a singly linked list kept in a store
// of alle_pkg::NODE_COUNT nodes, with unused nodes on a free list. The
// sequencer reads the link store at most once per cycle, so the cost per
// operation is set by the link walk: insert at head and delete at head read
// one node, an error result (store full, list empty) needs no read, read-out
// reads one element at a time, and insert at tail walks the nodes already in
// the list to the last one. Two-entry queues on both sides let new
// transactions be taken and results be drained while the sequencer works.
// Read-out stalls when the result queue is full and resumes where it left
// off. Node data is undefined until written; only written data is returned.
module array_linked_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_item_value,
    output logic               o_is_last
);

    alle_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    alle_pkg::t_res res_in;
    alle_pkg::t_res res_out;
    logic           res_push;
    logic           res_full;

    alle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    alle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    alle_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_status     = res_out.status;
    assign o_item_value = res_out.item_value;
    assign o_is_last    = res_out.is_last;

endmodule
